FILE: design/brf_pkg.sv
package brf_pkg;

  localparam int PTR_W  = 8;
  localparam int BYTE_W = 8;

  localparam logic [2:0] MODE_WRITE   = 3'd0;
  localparam logic [2:0] MODE_PEEK    = 3'd1;
  localparam logic [2:0] MODE_CONSUME = 3'd2;
  localparam logic [2:0] MODE_CLEAR   = 3'd3;
  localparam logic [2:0] MODE_FIND    = 3'd4;
  localparam logic [2:0] MODE_GET     = 3'd5;

  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // Request from the sequencer to the byte store.
  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } mem_req_t;

endpackage

FILE: design/brf_ram.sv
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/brf_seq.sv
module brf_seq
  import brf_pkg::*;
#(
  parameter int SIZE_CAP = 256,
  parameter int MAX_READ = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        mode,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [7:0]        count,
  input  logic [7:0]        position,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] read_byte,
  output logic              status,
  output logic [7:0]        found_offset,
  output logic [7:0]        used_length,
  output logic              last,
  input  logic              cfg_write_en,
  input  logic [8:0]        cfg_write_data,
  output mem_req_t          mem_req,
  input  logic [BYTE_W-1:0] mem_rdata
);

  localparam logic [8:0] CAP      = 9'(SIZE_CAP);
  localparam logic [7:0] READ_MAX = 8'(MAX_READ);

  typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_READ, ST_GET, ST_FIND} state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              status;
    logic [7:0]        found_offset;
    logic [7:0]        used_length;
    logic              last;
  } res_t;

  state_t            state;
  logic [8:0]        ring_size;
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic [7:0]        used;
  logic [2:0]        mode_r;
  logic [BYTE_W-1:0] data_r;
  logic [7:0]        cnt_r;
  logic [7:0]        pos_r;
  logic [PTR_W-1:0]  rd_ptr;
  logic [7:0]        rd_cnt;
  res_t              res;

  logic [8:0] size_eff;
  logic       out_free;
  logic       write_ok;
  logic       read_reject;
  logic       pos_ok;
  logic [7:0] clr_cnt;
  logic       rd_last;
  logic       scan_end;
  logic       match;

  function automatic logic [PTR_W-1:0] mod_add(input logic [PTR_W-1:0] p,
                                                input logic [7:0] x,
                                                input logic [8:0] s);
    logic [8:0] sum;
    sum = {1'b0, p} + {1'b0, x};
    if (sum >= s) begin
      sum = sum - s;
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic res_t make_res(input logic [BYTE_W-1:0] rb, input logic st,
                                    input logic [7:0] fo, input logic [7:0] ul,
                                    input logic lst);
    res_t r;
    r.read_byte    = rb;
    r.status       = st;
    r.found_offset = fo;
    r.used_length  = ul;
    r.last         = lst;
    return r;
  endfunction

  always_comb begin
    if (ring_size < 9'd2) begin
      size_eff = 9'd2;
    end else if (ring_size > CAP) begin
      size_eff = CAP;
    end else begin
      size_eff = ring_size;
    end
  end

  assign out_free    = !out_valid || !out_stall;
  assign write_ok    = ({1'b0, used} + 9'd1) < size_eff;
  assign read_reject = (cnt_r == 8'd0) || (cnt_r > READ_MAX) || (cnt_r > used);
  assign pos_ok      = pos_r < used;
  assign clr_cnt     = (cnt_r > used) ? used : cnt_r;
  assign rd_last     = ({1'b0, rd_cnt} + 9'd1) == {1'b0, cnt_r};
  assign scan_end    = ({1'b0, rd_cnt} + 9'd1) == {1'b0, used};
  assign match       = mem_rdata == data_r;
  assign in_stall    = state != ST_IDLE;

  always_comb begin
    mem_req       = '0;
    mem_req.waddr = tail;
    mem_req.wdata = data_r;
    mem_req.raddr = rd_ptr;
    unique case (state)
      ST_EXEC: begin
        unique case (mode_r)
          MODE_WRITE: mem_req.we = out_free && write_ok;
          MODE_PEEK, MODE_CONSUME: begin
            mem_req.re    = !read_reject;
            mem_req.raddr = head;
          end
          MODE_FIND: begin
            mem_req.re    = used != 8'd0;
            mem_req.raddr = head;
          end
          MODE_GET: begin
            mem_req.re    = pos_ok;
            mem_req.raddr = mod_add(head, pos_r, size_eff);
          end
          default: mem_req.re = 1'b0;
        endcase
      end
      ST_READ: mem_req.re = out_free && !rd_last;
      ST_FIND: mem_req.re = !match && !scan_end;
      default: mem_req.re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ring_size <= 9'd256;
      head      <= '0;
      tail      <= '0;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            mode_r <= mode;
            data_r <= data_byte;
            cnt_r  <= count;
            pos_r  <= position;
            state  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          unique case (mode_r)
            MODE_WRITE: begin
              if (out_free) begin
                out_valid <= 1'b1;
                if (write_ok) begin
                  res  <= make_res('0, STATUS_DONE, '0, used + 8'd1, 1'b1);
                  tail <= mod_add(tail, 8'd1, size_eff);
                  used <= used + 8'd1;
                end else begin
                  res <= make_res('0, STATUS_REJECT, '0, used, 1'b1);
                end
                state <= ST_IDLE;
              end
            end
            MODE_PEEK, MODE_CONSUME: begin
              if (!read_reject) begin
                rd_ptr <= mod_add(head, 8'd1, size_eff);
                rd_cnt <= '0;
                state  <= ST_READ;
              end else if (out_free) begin
                out_valid <= 1'b1;
                res       <= make_res('0, STATUS_REJECT, '0, used, 1'b1);
                state     <= ST_IDLE;
              end
            end
            MODE_CLEAR: begin
              if (out_free) begin
                out_valid <= 1'b1;
                res       <= make_res('0, STATUS_DONE, '0, used - clr_cnt, 1'b1);
                head      <= mod_add(head, clr_cnt, size_eff);
                used      <= used - clr_cnt;
                state     <= ST_IDLE;
              end
            end
            MODE_FIND: begin
              if (used != 8'd0) begin
                rd_ptr <= mod_add(head, 8'd1, size_eff);
                rd_cnt <= '0;
                state  <= ST_FIND;
              end else if (out_free) begin
                out_valid <= 1'b1;
                res       <= make_res('0, STATUS_REJECT, '0, used, 1'b1);
                state     <= ST_IDLE;
              end
            end
            MODE_GET: begin
              if (pos_ok) begin
                state <= ST_GET;
              end else if (out_free) begin
                out_valid <= 1'b1;
                res       <= make_res('0, STATUS_REJECT, '0, used, 1'b1);
                state     <= ST_IDLE;
              end
            end
            default: begin
              if (out_free) begin
                out_valid <= 1'b1;
                res       <= make_res('0, STATUS_REJECT, '0, used, 1'b1);
                state     <= ST_IDLE;
              end
            end
          endcase
        end
        ST_READ: begin
          // The next read is issued in the same cycle as the beat, so a
          // block streams one byte per cycle while the output keeps up.
          if (out_free) begin
            out_valid <= 1'b1;
            res <= make_res(mem_rdata, STATUS_DONE, '0,
                            (mode_r == MODE_CONSUME) ? used - cnt_r : used, rd_last);
            if (rd_last) begin
              if (mode_r == MODE_CONSUME) begin
                head <= mod_add(head, cnt_r, size_eff);
                used <= used - cnt_r;
              end
              state <= ST_IDLE;
            end else begin
              rd_ptr <= mod_add(rd_ptr, 8'd1, size_eff);
              rd_cnt <= rd_cnt + 8'd1;
            end
          end
        end
        ST_GET: begin
          if (out_free) begin
            out_valid <= 1'b1;
            res       <= make_res(mem_rdata, STATUS_DONE, '0, used, 1'b1);
            state     <= ST_IDLE;
          end
        end
        ST_FIND: begin
          if (match) begin
            if (out_free) begin
              out_valid <= 1'b1;
              res       <= make_res('0, STATUS_DONE, rd_cnt, used, 1'b1);
              state     <= ST_IDLE;
            end
          end else if (scan_end) begin
            if (out_free) begin
              out_valid <= 1'b1;
              res       <= make_res('0, STATUS_REJECT, '0, used, 1'b1);
              state     <= ST_IDLE;
            end
          end else begin
            rd_ptr <= mod_add(rd_ptr, 8'd1, size_eff);
            rd_cnt <= rd_cnt + 8'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // Writing the ring size empties the FIFO.
      if (cfg_write_en) begin
        ring_size <= cfg_write_data;
        head      <= '0;
        tail      <= '0;
        used      <= '0;
      end
    end
  end

  assign read_byte    = res.read_byte;
  assign status       = res.status;
  assign found_offset = res.found_offset;
  assign used_length  = res.used_length;
  assign last         = res.last;

endmodule

FILE: design/byte_ring_fifo_with_search.sv
// Byte ring FIFO with search. One request is taken at a time: after a request
// is accepted, in_stall stays high until its last result beat has been loaded
// into the output register. Writes, clears, rejected requests and unused modes
// give a single beat; a get first reads its byte; a peek or consume of N bytes
// gives N beats; a find reads up to all held bytes in order. The byte store has
// a single read port with registered read data, which delivers one byte per
// cycle while the output is not stalled.
// Writing ring_size empties the FIFO. The byte store has no reset.
module byte_ring_fifo_with_search
  import brf_pkg::*;
#(
  parameter int DEPTH    = 256,
  parameter int MAX_READ = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        mode,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [7:0]        count,
  input  logic [7:0]        position,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] read_byte,
  output logic              status,
  output logic [7:0]        found_offset,
  output logic [7:0]        used_length,
  output logic              last,
  input  logic              cfg_write_en,
  input  logic [8:0]        cfg_write_data
);

  localparam int MEM_DEPTH = (DEPTH < 256) ? DEPTH : 256;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  mem_req_t          mem_req;
  logic [BYTE_W-1:0] mem_rdata;

  brf_seq #(
    .SIZE_CAP (MEM_DEPTH),
    .MAX_READ (MAX_READ)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .data_byte      (data_byte),
    .count          (count),
    .position       (position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_byte      (read_byte),
    .status         (status),
    .found_offset   (found_offset),
    .used_length    (used_length),
    .last           (last),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata)
  );

  brf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr[AW-1:0]),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr[AW-1:0]),
    .rdata (mem_rdata)
  );

  // Only one request is in flight.
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another is in progress");

  // A block read streams without gaps once it has started.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |=> out_valid)
    else $error("result beat missing inside a block read");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> read_byte == 8'd0 && found_offset == 8'd0)
    else $error("rejected result carries data");

  a_found_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && found_offset != 8'd0 |-> found_offset < used_length)
    else $error("find offset beyond held bytes");

endmodule

FILE: tb/sv/ring_fifo_checker.sv
`timescale 1ns / 1ps
module ring_fifo_checker
  import brf_pkg::*;
#(
  parameter int DEPTH    = 256,
  parameter int MAX_READ = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  count,
  input  logic [7:0]  position,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  read_byte,
  input  logic        status,
  input  logic [7:0]  found_offset,
  input  logic [7:0]  used_length,
  input  logic        last,
  input  logic        cfg_write_en,
  input  logic [8:0]  cfg_write_data,
  output int          error_count,
  output int          beats_pending,
  output int          fill_level,
  output int          requests_seen,
  output int          beats_checked
);

  typedef struct packed {
    logic [7:0] read_byte;
    logic       status;
    logic [7:0] found_offset;
    logic [7:0] used_length;
    logic       last;
  } fifo_beat_t;

  logic [7:0] byte_mem [0:DEPTH-1];
  int         head_ptr;
  int         tail_ptr;
  logic [8:0] ring_cfg;
  fifo_beat_t expected_beats [$];
  fifo_beat_t seen_beat;
  int         errors;
  int         n_requests;
  int         n_beats;

  initial begin
    for (int i = 0; i < DEPTH; i++) byte_mem[i] = 8'h00;
    head_ptr   = 0;
    tail_ptr   = 0;
    ring_cfg   = 9'd256;
    errors     = 0;
    n_requests = 0;
    n_beats    = 0;
  end

  // Register values outside 2..256 behave as the nearest legal size.
  function automatic int effective_slots();
    int s;
    s = int'(ring_cfg);
    if (s < 2) s = 2;
    if (s > 256) s = 256;
    if (s > DEPTH) s = DEPTH;
    return s;
  endfunction

  function automatic int held_bytes(input int s);
    return (tail_ptr + s - head_ptr) % s;
  endfunction

  function automatic logic [7:0] byte_at(input int s, input int off);
    return byte_mem[(head_ptr + off) % s];
  endfunction

  task automatic predict_request(input logic [2:0] m, input logic [7:0] d,
                                 input logic [7:0] c, input logic [7:0] p);
    int         s;
    int         used;
    int         cnt;
    int         n;
    int         i;
    bit         found;
    fifo_beat_t b;
    s      = effective_slots();
    used   = held_bytes(s);
    cnt    = int'(c);
    b      = '0;
    b.status      = STATUS_REJECT;
    b.used_length = 8'(used);
    b.last        = 1'b1;
    case (m)
      MODE_WRITE: begin
        if (used + 1 < s) begin
          byte_mem[tail_ptr] = d;
          tail_ptr = (tail_ptr + 1) % s;
          b.status      = STATUS_DONE;
          b.used_length = 8'(used + 1);
        end
        expected_beats.push_back(b);
      end
      MODE_PEEK, MODE_CONSUME: begin
        if (cnt == 0 || cnt > MAX_READ || cnt > used) begin
          expected_beats.push_back(b);
        end else begin
          // All-or-nothing block read: one beat per byte, oldest first.
          b.status      = STATUS_DONE;
          b.used_length = 8'((m == MODE_CONSUME) ? used - cnt : used);
          for (i = 0; i < cnt; i++) begin
            b.read_byte = byte_at(s, i);
            b.last      = (i == cnt - 1);
            expected_beats.push_back(b);
          end
          if (m == MODE_CONSUME) head_ptr = (head_ptr + cnt) % s;
        end
      end
      MODE_CLEAR: begin
        n = (cnt > used) ? used : cnt;
        head_ptr = (head_ptr + n) % s;
        b.status      = STATUS_DONE;
        b.used_length = 8'(used - n);
        expected_beats.push_back(b);
      end
      MODE_FIND: begin
        found = 1'b0;
        for (i = 0; i < used && !found; i++) begin
          if (byte_at(s, i) == d) begin
            found          = 1'b1;
            b.status       = STATUS_DONE;
            b.found_offset = 8'(i);
          end
        end
        expected_beats.push_back(b);
      end
      MODE_GET: begin
        if (int'(p) < used) begin
          b.status    = STATUS_DONE;
          b.read_byte = byte_at(s, int'(p));
        end
        expected_beats.push_back(b);
      end
      default: expected_beats.push_back(b);
    endcase
  endtask

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch on beat %0d: expected %0d, actual %0d",
               $time, name, n_beats, want, got);
    end
  endtask

  task automatic check_beat(input fifo_beat_t got);
    fifo_beat_t want;
    if (expected_beats.size() == 0) begin
      errors++;
      $display("%0t: extra beat: expected none, actual %0d/%0d/%0d/%0d/%0d",
               $time, got.read_byte, got.status, got.found_offset,
               got.used_length, got.last);
      return;
    end
    want = expected_beats.pop_front();
    n_beats++;
    report_field("read_byte", int'(want.read_byte), int'(got.read_byte));
    report_field("status", int'(want.status), int'(got.status));
    report_field("found_offset", int'(want.found_offset), int'(got.found_offset));
    report_field("used_length", int'(want.used_length), int'(got.used_length));
    report_field("last", int'(want.last), int'(got.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head_ptr = 0;
      tail_ptr = 0;
      ring_cfg = 9'd256;
      expected_beats.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen_beat = {read_byte, status, found_offset, used_length, last};
        check_beat(seen_beat);
      end
      // A size write also empties the ring.
      if (cfg_write_en) begin
        ring_cfg = cfg_write_data;
        head_ptr = 0;
        tail_ptr = 0;
      end
      if (in_valid && !in_stall) begin
        predict_request(mode, data_byte, count, position);
        n_requests++;
      end
    end
    error_count   <= errors;
    beats_pending <= expected_beats.size();
    fill_level    <= held_bytes(effective_slots());
    requests_seen <= n_requests;
    beats_checked <= n_beats;
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import brf_pkg::*;

  localparam int DEPTH        = 256;
  localparam int MAX_READ     = 64;
  localparam int CYCLE_LIMIT  = 10000000;
  localparam int LATENCY_TAIL = 300;
  localparam int LONG_HOLD    = 300;
  localparam int NUM_PHASES   = 10;

  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] mode;
  logic [7:0] data_byte;
  logic [7:0] count;
  logic [7:0] position;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] read_byte;
  logic       status;
  logic [7:0] found_offset;
  logic [7:0] used_length;
  logic       last;
  logic       cfg_write_en;
  logic [8:0] cfg_write_data;

  int error_count;
  int beats_pending;
  int fill_level;
  int requests_seen;
  int beats_checked;

  int cur_slots;
  int hold_asks;
  int configs_written;
  bit offering;

  byte_ring_fifo_with_search #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .data_byte      (data_byte),
    .count          (count),
    .position       (position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_byte      (read_byte),
    .status         (status),
    .found_offset   (found_offset),
    .used_length    (used_length),
    .last           (last),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  ring_fifo_checker #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .data_byte      (data_byte),
    .count          (count),
    .position       (position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_byte      (read_byte),
    .status         (status),
    .found_offset   (found_offset),
    .used_length    (used_length),
    .last           (last),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .error_count    (error_count),
    .beats_pending  (beats_pending),
    .fill_level     (fill_level),
    .requests_seen  (requests_seen),
    .beats_checked  (beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped at the cycle limit with %0d beats outstanding", beats_pending);
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: stretches of calm and of random stalls, plus long hold-offs on request.
  initial begin : receiver
    int holds_done;
    int stretch;
    int stall_pct;
    int n;
    holds_done = 0;
    stretch    = 0;
    stall_pct  = 0;
    forever begin
      if (stretch <= 0) begin
        stretch   = $urandom_range(50, 300);
        stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 40);
      end
      if (hold_asks != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if ($urandom_range(99) < stall_pct) begin
        n = ($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        stretch = stretch - n;
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
        stretch--;
      end
    end
  end

  function automatic int clamp_slots(input int v);
    if (v < 2) return 2;
    if (v > DEPTH) return DEPTH;
    return v;
  endfunction

  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // A few recurring values make searches hit more often than pure noise would.
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(3) != 0) return 8'($urandom_range(255));
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h55;
      default: return 8'hAA;
    endcase
  endfunction

  task automatic send_request(input logic [2:0] m, input logic [7:0] d,
                              input logic [7:0] c, input logic [7:0] p);
    in_valid  <= 1'b1;
    mode      <= m;
    data_byte <= d;
    count     <= c;
    position  <= p;
    offering  = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic lower_valid();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      lower_valid();
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    lower_valid();
    @(posedge clk);
    while (beats_pending != 0) @(posedge clk);
  endtask

  task automatic write_ring_size(input logic [8:0] v);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cur_slots = clamp_slots(int'(v));
    configs_written++;
  endtask

  task automatic random_request(input int write_pct);
    int         cap;
    int         lim;
    int         wp;
    logic [2:0] m;
    logic [7:0] d;
    logic [7:0] c;
    logic [7:0] p;
    cap = cur_slots - 1;
    wp  = (fill_level >= cap) ? write_pct / 4 : write_pct;
    lim = (fill_level < MAX_READ) ? fill_level : MAX_READ;
    d   = pick_byte();
    c   = 8'($urandom_range(255));
    p   = 8'($urandom_range(255));
    if ($urandom_range(99) < 5) begin
      m = 3'($urandom_range(7));
    end else begin
      if ($urandom_range(99) < wp) begin
        m = MODE_WRITE;
      end else begin
        case ($urandom_range(5))
          0:       m = MODE_PEEK;
          1, 2:    m = MODE_CONSUME;
          3:       m = MODE_CLEAR;
          4:       m = MODE_FIND;
          default: m = MODE_GET;
        endcase
      end
      case (m)
        MODE_PEEK, MODE_CONSUME: begin
          case ($urandom_range(9))
            0:       c = 8'd0;
            1:       c = ($urandom_range(1) == 0) ? 8'(MAX_READ + 1) : 8'd255;
            2:       c = (fill_level < 255) ? 8'(fill_level + 1) : 8'd255;
            default: c = (lim > 0) ? 8'($urandom_range(1, lim)) : 8'd1;
          endcase
        end
        MODE_CLEAR: begin
          case ($urandom_range(7))
            0:       c = 8'd0;
            1:       c = 8'd255;
            2:       c = 8'($urandom_range(255));
            default: c = 8'($urandom_range(1, 4));
          endcase
        end
        MODE_GET: begin
          case ($urandom_range(7))
            0:       p = 8'(fill_level);
            1:       p = ($urandom_range(1) == 0) ? 8'd254 : 8'd255;
            default: p = (fill_level > 0) ? 8'($urandom_range(0, fill_level - 1)) : 8'd0;
          endcase
        end
        default: ;
      endcase
    end
    send_request(m, d, c, p);
  endtask

  task automatic phase_plan(input int idx, output int ring, output int items,
                            output int fill_first);
    fill_first = 0;
    case (idx)
      0:       begin ring = 2;   items = 25;  end
      1:       begin ring = 3;   items = 25;  end
      2:       begin ring = 7;   items = 35;  end
      3:       begin ring = 256; items = 110; fill_first = 70; end
      4:       begin ring = 0;   items = 15;  end
      5:       begin ring = 1;   items = 15;  end
      6:       begin ring = 300; items = 60;  end
      7:       begin ring = 511; items = 20;  end
      8:       begin ring = 33;  items = 40;  end
      default: begin ring = $urandom_range(2, 256); items = 35; end
    endcase
  endtask

  initial begin : stimulus
    int ph;
    int k;
    int ring;
    int items;
    int fill_first;
    int gap_pct;
    int write_pct;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    mode           <= MODE_WRITE;
    data_byte      <= 8'h00;
    count          <= 8'h00;
    position       <= 8'h00;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= 9'd0;
    offering        = 1'b0;
    cur_slots       = 256;
    hold_asks       = 0;
    configs_written = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: a couple of beats at the reset size, then a tiny ring.
    send_request(MODE_WRITE, 8'h3C, 8'd0, 8'd0);
    send_request(MODE_GET, 8'h00, 8'd0, 8'd0);
    write_ring_size(9'd4);
    send_request(MODE_GET, 8'h00, 8'd0, 8'd0);
    send_request(MODE_FIND, 8'h00, 8'd0, 8'd0);
    send_request(MODE_PEEK, 8'h00, 8'd1, 8'd0);
    send_request(MODE_WRITE, 8'h00, 8'd0, 8'd0);
    pause_sender(2);
    send_request(MODE_WRITE, 8'hFF, 8'd255, 8'd255);
    send_request(MODE_PEEK, 8'h00, 8'd0, 8'd0);
    send_request(MODE_WRITE, 8'hA5, 8'd0, 8'd0);
    send_request(MODE_WRITE, 8'h11, 8'd0, 8'd0);
    send_request(MODE_PEEK, 8'h00, 8'd3, 8'd0);
    pause_sender(5);
    send_request(MODE_PEEK, 8'h00, 8'd4, 8'd0);
    send_request(MODE_FIND, 8'hA5, 8'd0, 8'd0);
    send_request(MODE_CONSUME, 8'h00, 8'd2, 8'd0);
    // These two wrap the tail around the end of the ring.
    send_request(MODE_WRITE, 8'h5A, 8'd0, 8'd0);
    send_request(MODE_WRITE, 8'hC3, 8'd0, 8'd0);
    send_request(MODE_FIND, 8'hC3, 8'd0, 8'd0);
    send_request(MODE_FIND, 8'h77, 8'd0, 8'd0);
    send_request(MODE_GET, 8'h00, 8'd0, 8'd2);
    send_request(MODE_GET, 8'h00, 8'd0, 8'd3);
    pause_sender(1);
    send_request(MODE_GET, 8'h00, 8'd0, 8'd255);
    send_request(MODE_CONSUME, 8'h00, 8'd255, 8'd0);
    send_request(MODE_CLEAR, 8'h00, 8'd0, 8'd0);
    send_request(MODE_CLEAR, 8'h00, 8'd255, 8'd0);
    send_request(MODE_SPARE_6, 8'hFF, 8'd255, 8'd255);
    send_request(MODE_SPARE_7, 8'h00, 8'd0, 8'd0);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      phase_plan(ph, ring, items, fill_first);
      write_ring_size(9'(ring));
      gap_pct   = (ph % 3 == 0) ? 0 : 35;
      write_pct = (fill_first > 0 || cur_slots > 128) ? 60 : 45;
      for (k = 0; k < items; k++) begin
        if (k < fill_first)
          send_request(MODE_WRITE, pick_byte(), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
        else
          random_request(write_pct);
        if (fill_first > 0 && k == fill_first - 1) begin
          // Longest legal read, then one byte past the limit.
          send_request(MODE_PEEK, 8'h00, 8'(MAX_READ), 8'd0);
          send_request(MODE_PEEK, 8'h00, 8'(MAX_READ + 1), 8'd0);
          // The receiver now holds off while requests keep coming.
          hold_asks++;
        end
        if (ph % 2 == 1 && k == items / 2)
          wait_drained();
        else
          pause_sender(pick_gap(gap_pct));
      end
    end

    wait_drained();
    repeat (LATENCY_TAIL) @(posedge clk);
    $display("Covered %0d requests over %0d ring size settings, %0d result beats checked",
             requests_seen, configs_written + 1, beats_checked);
    $display("Mismatches found: %0d", error_count);
    if (error_count == 0 && beats_pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: byte_ring_fifo_with_search.f
design/brf_pkg.sv
design/brf_ram.sv
design/brf_seq.sv
design/byte_ring_fifo_with_search.sv
tb/sv/ring_fifo_checker.sv
tb/sv/tb.sv
